>>> rtl/lrs_pkg.sv
`timescale 1ns / 1ps
// Package for the LCD refresh sequencer: shared types, constants and the line glyph table.
// It depends on nothing. lrs_cmd_if and all modules use it.
package lrs_pkg;

    localparam int unsigned LINE_LENGTH = 16;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned TEMP_W      = 10;
    localparam int unsigned DELAY_W     = 16;
    localparam int unsigned ELAPSED_W   = 17;

    localparam logic [7:0]           CMD_HOME    = 8'h02;
    localparam logic [7:0]           GLYPH_DIGIT = 8'h30;
    localparam logic [9:0]           TEMP_MAX    = 10'd999;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [DELAY_W-1:0]   DELAY_RESET = 16'd2;

    // These are the positions in the line that show temperature digits.
    localparam logic [POS_W-1:0] POS_TENS  = 5'd10;
    localparam logic [POS_W-1:0] POS_ONES  = 5'd11;
    localparam logic [POS_W-1:0] POS_TENTH = 5'd13;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_LOAD = 1'b1
    } t_action;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
        logic [3:0] tenth;
    } t_digits;

    // This returns the fixed text of the line. The digit positions are overridden elsewhere.
    function automatic logic [7:0] line_glyph(input logic [3:0] pos);
        logic [7:0] g;
        case (pos)
            4'd0:    g = 8'h43; // C
            4'd1:    g = 8'h50; // P
            4'd2:    g = 8'h55; // U
            4'd3:    g = 8'h20;
            4'd4:    g = 8'h54; // T
            4'd5:    g = 8'h65; // e
            4'd6:    g = 8'h6D; // m
            4'd7:    g = 8'h70; // p
            4'd8:    g = 8'h3A; // :
            4'd9:    g = 8'h20;
            4'd10:   g = 8'h30;
            4'd11:   g = 8'h30;
            4'd12:   g = 8'h2E; // .
            4'd13:   g = 8'h30;
            4'd14:   g = 8'hDF; // degree sign
            4'd15:   g = 8'h43; // C
            default: g = 8'h20;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/lrs_cmd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries command transactions into the sequencer.
// It depends on lrs_pkg for the field widths.
interface lrs_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [lrs_pkg::TEMP_W-1:0]    temp_tenths;

    modport source (output valid, output action, output temp_tenths, input ready);
    modport sink   (input valid, input action, input temp_tenths, output ready);
endinterface

>>> rtl/lrs_pins_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries LCD pin level transactions out of the sequencer.
// It has no dependencies.
interface lrs_pins_if;
    logic       valid;
    logic       ready;
    logic       rs_pin;
    logic       enable_pin;
    logic [7:0] data_pins;

    modport source (output valid, output rs_pin, output enable_pin, output data_pins, input ready);
    modport sink   (input valid, input rs_pin, input enable_pin, input data_pins, output ready);
endinterface

>>> rtl/lrs_digit_split.sv
`timescale 1ns / 1ps
// Splits a temperature in tenths of a degree into three decimal digits, with clamping.
// It depends on lrs_pkg for t_digits and the temperature limit.
module lrs_digit_split (
    input  logic [lrs_pkg::TEMP_W-1:0] i_temp,
    output lrs_pkg::t_digits           o_digits
);

    logic [9:0] w_t;
    logic [3:0] w_hund;
    logic [6:0] w_rem;
    logic [3:0] w_ten;
    logic [3:0] w_unit;

    // Each digit is found by comparing against all nine thresholds in parallel.
    always_comb begin
        w_t    = (i_temp > lrs_pkg::TEMP_MAX) ? lrs_pkg::TEMP_MAX : i_temp;
        w_hund = '0;
        w_rem  = w_t[6:0];
        for (int k = 1; k <= 9; k++) begin
            if (w_t >= 10'(k * 100)) begin
                w_hund = 4'(k);
                w_rem  = 7'(w_t - 10'(k * 100));
            end
        end
        w_ten  = '0;
        w_unit = w_rem[3:0];
        for (int k = 1; k <= 9; k++) begin
            if (w_rem >= 7'(k * 10)) begin
                w_ten  = 4'(k);
                w_unit = 4'(w_rem - 7'(k * 10));
            end
        end
    end

    assign o_digits.tens  = w_hund;
    assign o_digits.ones  = w_ten;
    assign o_digits.tenth = w_unit;

endmodule

>>> rtl/lcd_refresh_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level of the LCD refresh sequencer. It depends on lrs_pkg, lrs_cmd_if,
// lrs_pins_if and lrs_digit_split.
//
// Usage: each command transaction on i_cmd is either a timer tick or a load of a
// new temperature in tenths of a degree. Every command produces exactly one
// transaction on o_pins that carries the RS, E and DB0..DB7 levels after that
// command's update. Ticks step through the text "CPU Temp: dd.d", a degree sign
// and C, then a cursor-home instruction, and then start over. Every write raises
// E, holds it until more than enable_delay_ticks ticks have passed, drops it and
// waits the same way before the next write. A temperature load only changes the
// digits shown in later writes; values above 999 are clamped.
// i_cfg_we writes enable_delay_ticks from i_cfg_wdata; the user must write it only
// while idle; the block does not enforce this. Timing: a command is captured in an
// input register and its result lands in the output register once that one is free
// or being drained. While o_pins is not stalled, one command is taken per cycle with
// no bubbles; the single pass of update logic between the two registers sets that
// rate. When o_pins is stalled, the held result stays put and one more command can
// sit in the input register; i_cmd.ready then drops until the output is taken.
// Reset (synchronous, active low) clears the pins, digits and sequence position and
// sets the delay to two ticks.
module lcd_refresh_sequencer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lrs_pkg::DELAY_W-1:0]    i_cfg_wdata,
    lrs_cmd_if.sink                        i_cmd,
    lrs_pins_if.source                     o_pins
);

    // Input register.
    logic                              r_s1_valid;
    logic                              r_s1_action;
    logic [lrs_pkg::TEMP_W-1:0]        r_s1_temp;

    // Configuration.
    logic [lrs_pkg::DELAY_W-1:0]       r_delay;

    // Sequencer state; the pin registers also serve as the output payload.
    logic                              r_out_valid;
    logic                              r_waiting,   n_waiting;
    logic                              r_en_high,   n_en_high;
    logic [lrs_pkg::ELAPSED_W-1:0]     r_elapsed,   n_elapsed;
    logic [lrs_pkg::POS_W-1:0]         r_pos,       n_pos;
    lrs_pkg::t_digits                  r_digits,    n_digits;
    logic                              r_rs,        n_rs;
    logic [7:0]                        r_bus,       n_bus;

    logic                              w_adv;
    logic [lrs_pkg::ELAPSED_W-1:0]     w_el_inc;
    logic [7:0]                        w_glyph;
    lrs_pkg::t_digits                  w_split;

    lrs_digit_split u_digit_split (
        .i_temp   (r_s1_temp),
        .o_digits (w_split)
    );

    // The held command moves on whenever the output register is free or being drained.
    assign w_adv       = r_s1_valid && (!r_out_valid || o_pins.ready);
    assign i_cmd.ready = !r_s1_valid || w_adv;

    assign o_pins.valid      = r_out_valid;
    assign o_pins.rs_pin     = r_rs;
    assign o_pins.enable_pin = r_en_high;
    assign o_pins.data_pins  = r_bus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_s1_action <= i_cmd.action;
            r_s1_temp   <= i_cmd.temp_tenths;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= lrs_pkg::DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_wdata;
        end
    end

    // Saturating tick counter increment.
    assign w_el_inc = (r_elapsed == lrs_pkg::ELAPSED_MAX) ? r_elapsed
                                                          : r_elapsed + 1'b1;

    // The three digit positions take their glyph from the stored digits.
    always_comb begin
        if (r_pos == lrs_pkg::POS_TENS) begin
            w_glyph = lrs_pkg::GLYPH_DIGIT | {4'd0, r_digits.tens};
        end else if (r_pos == lrs_pkg::POS_ONES) begin
            w_glyph = lrs_pkg::GLYPH_DIGIT | {4'd0, r_digits.ones};
        end else if (r_pos == lrs_pkg::POS_TENTH) begin
            w_glyph = lrs_pkg::GLYPH_DIGIT | {4'd0, r_digits.tenth};
        end else begin
            w_glyph = lrs_pkg::line_glyph(r_pos[3:0]);
        end
    end

    // Next state for one command. A load stores new digits. A tick either keeps waiting,
    // ends the high phase of E, or ends the low phase (if any) and starts the next write.
    always_comb begin
        logic start_write;
        start_write = 1'b0;
        n_waiting   = r_waiting;
        n_en_high   = r_en_high;
        n_elapsed   = r_elapsed;
        n_pos       = r_pos;
        n_digits    = r_digits;
        n_rs        = r_rs;
        n_bus       = r_bus;
        if (r_s1_action == lrs_pkg::ACT_LOAD) begin
            n_digits = w_split;
        end else if (r_waiting) begin
            if (w_el_inc <= {1'b0, r_delay}) begin
                n_elapsed = w_el_inc;
            end else if (r_en_high) begin
                n_en_high = 1'b0;
                n_elapsed = '0;
            end else begin
                start_write = 1'b1;
            end
        end else begin
            start_write = 1'b1;
        end
        if (start_write) begin
            n_en_high = 1'b1;
            n_waiting = 1'b1;
            n_elapsed = '0;
            if (r_pos >= lrs_pkg::POS_W'(lrs_pkg::LINE_LENGTH)) begin
                // End of the line: send cursor-home as an instruction.
                n_pos = '0;
                n_rs  = 1'b0;
                n_bus = lrs_pkg::CMD_HOME;
            end else begin
                n_pos = r_pos + 1'b1;
                n_rs  = 1'b1;
                n_bus = w_glyph;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_waiting   <= 1'b0;
            r_en_high   <= 1'b0;
            r_elapsed   <= '0;
            r_pos       <= '0;
            r_digits    <= '0;
            r_rs        <= 1'b0;
            r_bus       <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_waiting   <= n_waiting;
                r_en_high   <= n_en_high;
                r_elapsed   <= n_elapsed;
                r_pos       <= n_pos;
                r_digits    <= n_digits;
                r_rs        <= n_rs;
                r_bus       <= n_bus;
            end else if (o_pins.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
